// ===== src/tal_pkg.sv =====
// shared types, constants and the level quantizer for the tilt axis level tracker
package tal_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CMP_W      = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // quantizer band edges and report bits
  localparam logic [17:0] BAND_ZERO = 18'd90;
  localparam logic [17:0] BAND_ONE  = 18'd140;
  localparam logic [17:0] BAND_TWO  = 18'd160;
  localparam logic [17:0] BAND_THR  = 18'd180;
  localparam logic [17:0] BAND_FOUR = 18'd200;
  localparam logic [17:0] BAND_FIVE = 18'd220;
  localparam logic [6:0]  LEVEL_NEG = 7'h40;
  localparam logic [3:0]  PEND_MASK = 4'hF;

  // configuration reset values
  localparam logic [11:0] RST_X_THR    = 12'd100;
  localparam logic [11:0] RST_Y_THR    = 12'd90;
  localparam logic [11:0] RST_NEG_THR  = 12'd90;
  localparam logic [7:0]  RST_HALF_W   = 8'd6;
  localparam logic [7:0]  RST_SETTLE   = 8'd10;
  localparam logic [3:0]  RST_IDLE_REP = 4'd10;
  localparam logic [7:0]  RST_X_BIAS   = 8'd10;

  typedef enum logic [2:0] {
    CFG_X_THR    = 3'd0,
    CFG_Y_THR    = 3'd1,
    CFG_NEG_THR  = 3'd2,
    CFG_HALF_W   = 3'd3,
    CFG_SETTLE   = 3'd4,
    CFG_IDLE_REP = 3'd5,
    CFG_X_BIAS   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] x_thr;
    logic [11:0] y_thr;
    logic [11:0] neg_thr;
    logic [7:0]  half_w;
    logic [7:0]  settle;
    logic [3:0]  idle_rep;
    logic [7:0]  x_bias;
  } cfg_t;

  typedef struct packed {
    logic               axis;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] report;
    logic       report_valid;
    logic       finished;
  } out_item_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic               axis;
    logic signed [15:0] sample;
    logic               start_hit;
    logic [7:0]         bias;
    logic [6:0]         lv;
  } cls_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [6:0] quantize(input logic signed [17:0] v);
    logic [17:0] m;
    logic [6:0]  sgn;
    logic [6:0]  res;
    m   = v[17] ? 18'(-v) : 18'(v);
    sgn = v[17] ? LEVEL_NEG : 7'd0;
    if (m < BAND_ZERO) begin
      res = 7'd0;
    end else if (m < BAND_ONE) begin
      res = sgn | 7'd1;
    end else if (m < BAND_TWO) begin
      res = sgn | 7'd2;
    end else if (m < BAND_THR) begin
      res = sgn | 7'd3;
    end else if (m < BAND_FOUR) begin
      res = sgn | 7'd4;
    end else if (m < BAND_FIVE) begin
      res = sgn | 7'd5;
    end else begin
      res = sgn | 7'd6;
    end
    return res;
  endfunction

endpackage

// ===== src/tal_front.sv =====
// front end: classifies an incoming sample (start test, bias, sample level)
module tal_front import tal_pkg::*; (
  input  in_item_t  in_data_i,
  input  cfg_t      cfg_i,
  output cls_item_t cls_o
);

  logic signed [16:0] s_x;
  logic signed [16:0] pos_thr;
  logic signed [16:0] neg_lim;
  logic [7:0]         bias;
  logic signed [17:0] biased;

  assign s_x     = 17'(in_data_i.sample);
  assign pos_thr = $signed({5'b0, (in_data_i.axis ? cfg_i.y_thr : cfg_i.x_thr)});
  assign neg_lim = 17'sd0 - $signed({5'b0, cfg_i.neg_thr});

  // positive x samples carry the bias
  assign bias   = (!in_data_i.axis && (in_data_i.sample > 16'sd0)) ? cfg_i.x_bias : 8'd0;
  assign biased = 18'(in_data_i.sample) - $signed({10'b0, bias});

  always_comb begin
    cls_o.axis      = in_data_i.axis;
    cls_o.sample    = in_data_i.sample;
    cls_o.start_hit = (s_x > pos_thr) || (s_x < neg_lim);
    cls_o.bias      = bias;
    cls_o.lv        = quantize(biased);
  end

endmodule

// ===== src/tal_fifo.sv =====
// short queue of classified items between front and back
module tal_fifo import tal_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cls_item_t push_data_i,
  input  logic      pop_i,
  output cls_item_t pop_data_o,
  output q_status_t status_o
);

  cls_item_t          mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);
  localparam logic [Q_CNT_W-1:0] CNT_FULL = Q_CNT_W'(Q_DEPTH);

  assign status_o.full  = (cnt_q == CNT_FULL);
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/tal_back.sv =====
// back end: per-axis run tracking and the registered result stage
module tal_back import tal_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  cls_item_t item_i,
  input  logic      item_avail_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [COUNT_BITS-1:0] run_cnt_q [2];
  logic signed [15:0]    centre_q  [2];
  logic [6:0]            level_q   [2];
  logic [3:0]            idle_q    [2];
  logic                  pend_q    [2];
  logic [1:0]            quiet;

  logic [COUNT_BITS-1:0] rc, rc_inc, rc_d;
  logic signed [15:0]    centre, centre_d;
  logic [6:0]            level, level_d;
  logic [3:0]            idle, idle_d, idle_inc;
  logic                  pend, pend_d;
  logic                  a;

  logic signed [17:0] s_x, c_x, lo, hi, c_biased;
  logic               in_win;
  logic [6:0]         settle_lv;

  logic       emit;
  out_item_t  res;
  logic       out_valid_q;
  out_item_t  out_data_q;

  for (genvar i = 0; i < 2; i++) begin : g_quiet
    assign quiet[i] = (idle_q[i] == 4'd0) && (run_cnt_q[i] == '0);
  end

  assign a      = item_i.axis;
  assign rc     = run_cnt_q[a];
  assign centre = centre_q[a];
  assign level  = level_q[a];
  assign idle   = idle_q[a];
  assign pend   = pend_q[a];

  assign rc_inc   = (rc == COUNT_MAX) ? rc : rc + 1'b1;
  assign idle_inc = idle + 4'd1;

  assign s_x      = 18'(item_i.sample);
  assign c_x      = 18'(centre);
  assign lo       = c_x - $signed({10'b0, cfg_i.half_w});
  assign hi       = c_x + $signed({10'b0, cfg_i.half_w});
  assign in_win   = (s_x > lo) && (s_x < hi);
  assign c_biased = c_x - $signed({10'b0, item_i.bias});
  assign settle_lv = quantize(c_biased);

  // space in the result stage gates the whole back end
  assign pop_o = item_avail_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    rc_d     = rc;
    centre_d = centre;
    level_d  = level;
    idle_d   = idle;
    pend_d   = pend;
    emit     = 1'b0;
    res.report       = {a, 7'd0};
    res.report_valid = 1'b1;
    res.finished     = 1'b0;
    if (rc != '0) begin
      if (CMP_W'(rc) < CMP_W'(cfg_i.settle)) begin
        // settling inside the window
        if (in_win) begin
          rc_d = rc_inc;
          if (CMP_W'(rc_inc) == CMP_W'(cfg_i.settle)) begin
            level_d    = settle_lv;
            emit       = 1'b1;
            res.report = {a, settle_lv};
          end
        end else begin
          idle_d = 4'd1;
          rc_d   = '0;
        end
      end else begin
        // following the level
        if (item_i.lv != level) begin
          if (!pend) begin
            pend_d = 1'b1;
          end else begin
            rc_d = '0;
            if (item_i.lv == 7'd0) begin
              idle_d = 4'd1;
              emit   = 1'b1;
            end
          end
        end else begin
          rc_d = rc_inc;
          if ((rc_inc[3:0] & PEND_MASK) != 4'd0) begin
            pend_d = 1'b0;
          end
        end
      end
    end else if (item_i.start_hit) begin
      idle_d   = 4'd0;
      rc_d     = {{(COUNT_BITS-1){1'b0}}, 1'b1};
      pend_d   = 1'b0;
      centre_d = item_i.sample;
    end else if (idle != 4'd0) begin
      // idle zero reports
      emit   = 1'b1;
      idle_d = idle_inc;
      if (idle_inc == cfg_i.idle_rep) begin
        idle_d       = 4'd0;
        res.finished = quiet[!a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        run_cnt_q[i] <= '0;
        centre_q[i]  <= '0;
        level_q[i]   <= '0;
        idle_q[i]    <= '0;
        pend_q[i]    <= 1'b0;
      end
    end else if (pop_o) begin
      run_cnt_q[a] <= rc_d;
      centre_q[a]  <= centre_d;
      level_q[a]   <= level_d;
      idle_q[a]    <= idle_d;
      pend_q[a]    <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= pop_o && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/tilt_axis_level_tracker_core.sv =====
// top level of the tilt axis level tracker: config registers, front, queue and back
// Tracks tilt on two accelerometer axes and turns runs of steady samples into level
// reports. Each input item is one signed 16-bit sample tagged X (axis 0) or Y (axis 1).
// An idle axis starts a run on a sample beyond its start threshold; once settle_samples
// samples in a row sit strictly inside the window around the start sample, a level
// report goes out (bit7 axis Y, bit6 negative, bits 2..0 band). A confirmed change to
// level zero, or an axis falling back to idle, gives zero reports until idle_reports
// have gone out; the last one carries finished when the other axis is quiet as well.
// Throughput is one item per clock while the result register is not stalled: the front
// classifies the sample combinationally into a two-entry queue and the back does one
// read-modify-write of the per-axis state per item, so an accepted item's result goes
// through the queue and then the registered result stage. A stalled result holds the back
// end and the input stalls once the queue has filled.
// Items that cause no report are absorbed without an output. Configuration is written
// through cfg_we_i / cfg_idx_i / cfg_wdata_i and should only change while idle.
module tilt_axis_level_tracker_core import tal_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write port
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  // input items
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  cfg_t      cfg_q;
  cls_item_t cls;
  cls_item_t q_head;
  q_status_t q_stat;
  logic      push;
  logic      pop;

  // config registers, truncated to each field's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_thr    <= RST_X_THR;
      cfg_q.y_thr    <= RST_Y_THR;
      cfg_q.neg_thr  <= RST_NEG_THR;
      cfg_q.half_w   <= RST_HALF_W;
      cfg_q.settle   <= RST_SETTLE;
      cfg_q.idle_rep <= RST_IDLE_REP;
      cfg_q.x_bias   <= RST_X_BIAS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_X_THR:    cfg_q.x_thr    <= cfg_wdata_i;
        CFG_Y_THR:    cfg_q.y_thr    <= cfg_wdata_i;
        CFG_NEG_THR:  cfg_q.neg_thr  <= cfg_wdata_i;
        CFG_HALF_W:   cfg_q.half_w   <= cfg_wdata_i[7:0];
        CFG_SETTLE:   cfg_q.settle   <= cfg_wdata_i[7:0];
        CFG_IDLE_REP: cfg_q.idle_rep <= cfg_wdata_i[3:0];
        CFG_X_BIAS:   cfg_q.x_bias   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // front: classify the incoming sample
  tal_front u_front (
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .cls_o     (cls)
  );

  // accept whenever the queue has room
  assign in_stall_o = q_stat.full;
  assign push       = in_valid_i && !q_stat.full;

  tal_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cls),
    .pop_i       (pop),
    .pop_data_o  (q_head),
    .status_o    (q_stat)
  );

  // back: per-axis tracking and the result register
  tal_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (q_head),
    .item_avail_i (!q_stat.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // queue cannot be full and empty at once
  a_q_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // a result is never shown without report_valid
  a_rep_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.report_valid)
    else $error("result without report_valid");

  // finished only rides on a zero report
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.finished) |-> (out_data_o.report[6:0] == 7'd0))
    else $error("finished on a non-zero level");

  // nothing is popped from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule
